[rtl/cdq_pkg.sv]
// Shared constants and codes for the circular deque with indexed read.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH_DEFAULT         = 256;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

[rtl/cdq_store.sv]
// Single-port element store with registered read data.
`default_nettype none

module cdq_store #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int EW    = cdq_pkg::ELEMENT_WIDTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [EW-1:0] wdata,
   output logic      [EW-1:0] rdata
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/circular_deque_with_indexed_read_unit.sv]
// Deque in a circular store: read at index, push/pop at either end.
// An accepted request word passes through stage one and the response register.
// One request word per cycle unless req_stall; at most one store access per word.
// Head and fill update at acceptance, so the next word always sees the new state.
// Reset (synchronous): deque empty, head at slot zero, no response pending.
// The element store has no reset; only slots inside the fill count are ever read.
`default_nettype none

module circular_deque_with_indexed_read_unit #(
   parameter int DEPTH         = cdq_pkg::DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = cdq_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cdq_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [cdq_pkg::INDEX_W-1:0]   req_index,
   input  wire logic [cdq_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [cdq_pkg::DATA_W-1:0]    rsp_data,
   output logic      [cdq_pkg::COUNT_W-1:0]   rsp_count,
   output logic      [cdq_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int EW = ELEMENT_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > cdq_pkg::INDEX_W) ? FW : cdq_pkg::INDEX_W;

   // state
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;

   // stage one: store access in flight
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_from_mem_ff, s1_from_mem_in;
   logic [EW-1:0]                  s1_data_ff, s1_data_in;
   logic [cdq_pkg::COUNT_W-1:0]    s1_count_ff, s1_count_in;
   logic [cdq_pkg::STATUS_W-1:0]   s1_status_ff, s1_status_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [cdq_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [cdq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic          rsp_free, s1_move, req_fire;
   logic          is_full, is_empty, idx_ok;
   logic [AW-1:0] head_dec, head_inc;
   logic [AW-1:0] logical, slot, mem_addr;
   logic [AW:0]   slot_sum;
   logic          mem_wr, mem_rd;
   logic [EW-1:0] val_el, mem_rdata;

   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move   = s1_valid_ff & rsp_free;
   assign req_stall = s1_valid_ff & ~rsp_free;
   assign req_fire  = req_valid & ~req_stall;

   assign is_full  = (fill_ff == FW'(DEPTH));
   assign is_empty = (fill_ff == '0);
   assign idx_ok   = (CW'(req_index) < CW'(fill_ff));
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign val_el   = EW'(req_value);

   always_comb begin
      case (req_func)
         cdq_pkg::FUNC_READ: begin
            logical = AW'(req_index);
         end
         cdq_pkg::FUNC_POP_BACK: begin
            logical = AW'(fill_ff - FW'(1));
         end
         default: begin
            logical = AW'(fill_ff);
         end
      endcase
   end

   // logical position -> physical slot; terms below DEPTH when used, so one subtract
   assign slot_sum = {1'b0, head_ff} + {1'b0, logical};
   assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                  : AW'(slot_sum);

   always_comb begin
      head_in        = head_ff;
      fill_in        = fill_ff;
      mem_addr       = slot;
      mem_wr         = 1'b0;
      mem_rd         = 1'b0;
      s1_from_mem_in = 1'b0;
      s1_data_in     = '0;
      s1_status_in   = cdq_pkg::ST_OK;
      case (req_func)
         cdq_pkg::FUNC_READ: begin
            if (idx_ok) begin
               mem_rd         = 1'b1;
               s1_from_mem_in = 1'b1;
            end else begin
               s1_status_in = cdq_pkg::ST_RANGE;
            end
         end
         cdq_pkg::FUNC_PUSH_BACK: begin
            if (is_full) begin
               s1_status_in = cdq_pkg::ST_FULL;
            end else begin
               mem_wr     = 1'b1;
               fill_in    = fill_ff + FW'(1);
               s1_data_in = val_el;
            end
         end
         cdq_pkg::FUNC_PUSH_FRONT: begin
            mem_addr = head_dec;
            if (is_full) begin
               s1_status_in = cdq_pkg::ST_FULL;
            end else begin
               mem_wr     = 1'b1;
               head_in    = head_dec;
               fill_in    = fill_ff + FW'(1);
               s1_data_in = val_el;
            end
         end
         cdq_pkg::FUNC_POP_BACK: begin
            if (is_empty) begin
               s1_status_in = cdq_pkg::ST_EMPTY;
            end else begin
               mem_rd         = 1'b1;
               s1_from_mem_in = 1'b1;
               fill_in        = fill_ff - FW'(1);
            end
         end
         cdq_pkg::FUNC_POP_FRONT: begin
            mem_addr = head_ff;
            if (is_empty) begin
               s1_status_in = cdq_pkg::ST_EMPTY;
            end else begin
               mem_rd         = 1'b1;
               s1_from_mem_in = 1'b1;
               head_in        = head_inc;
               fill_in        = fill_ff - FW'(1);
            end
         end
         default: begin
            s1_status_in = cdq_pkg::ST_RANGE;
         end
      endcase
      s1_count_in = cdq_pkg::COUNT_W'(fill_in);
   end

   cdq_store #(
      .DEPTH (DEPTH),
      .EW    (EW),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .wr_en (req_fire & mem_wr),
      .rd_en (req_fire & mem_rd),
      .addr  (mem_addr),
      .wdata (val_el),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = s1_from_mem_ff ? cdq_pkg::DATA_W'(mem_rdata)
                                        : cdq_pkg::DATA_W'(s1_data_ff);
         rsp_count_in  = s1_count_ff;
         rsp_status_in = s1_status_ff;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_from_mem_ff <= s1_from_mem_in;
         s1_data_ff     <= s1_data_in;
         s1_count_ff    <= s1_count_in;
         s1_status_ff   <= s1_status_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/cdq_checker.sv]
// Port-level assertions for the deque, bound to the top level.
`default_nettype none

module cdq_checker #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [cdq_pkg::DATA_W-1:0]    rsp_data,
   input wire logic [cdq_pkg::COUNT_W-1:0]   rsp_count,
   input wire logic [cdq_pkg::STATUS_W-1:0]  rsp_status
);

   localparam logic [cdq_pkg::COUNT_W-1:0] FullCount = cdq_pkg::COUNT_W'(DEPTH);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word on offer after reset");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data) && $stable(rsp_count)
         && $stable(rsp_status))
      else $error("stalled response word changed");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::ST_FULL |-> rsp_count == FullCount)
      else $error("full status with room left");

   a_empty_means_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with elements held");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdq_pkg::ST_OK |-> rsp_data == '0)
      else $error("error response carries data");

endmodule

bind circular_deque_with_indexed_read_unit cdq_checker #(
   .DEPTH (DEPTH)
) u_cdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .rsp_count  (rsp_count),
   .rsp_status (rsp_status)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the circular deque with indexed read.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = cdq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 20;

   // func codes with no operation behind them
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
   localparam logic [cdq_pkg::FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [cdq_pkg::DATA_W-1:0]   data;
      logic [cdq_pkg::COUNT_W-1:0]  count;
      logic [cdq_pkg::STATUS_W-1:0] status;
   } deque_rsp_type;

   typedef struct {
      logic [cdq_pkg::FUNC_W-1:0]  func;
      logic [cdq_pkg::INDEX_W-1:0] index;
      logic [cdq_pkg::VALUE_W-1:0] value;
      bit                          typed;
      deque_rsp_type               rsp;
   } directed_row_type;

   typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} op_mix_type;
   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_type;

   localparam deque_rsp_type UNTYPED = '0;
   localparam int DIRECTED_ROWS = 23;

   // typed rows are checked against the values given here, the rest against the predictor
   directed_row_type directed_tbl [DIRECTED_ROWS] = '{
      '{cdq_pkg::FUNC_READ,       8'd0,  32'd0,         1'b1, '{32'd0, 9'd0, cdq_pkg::ST_RANGE}},
      '{cdq_pkg::FUNC_POP_BACK,   8'd0,  32'd0,         1'b1, '{32'd0, 9'd0, cdq_pkg::ST_EMPTY}},
      '{cdq_pkg::FUNC_POP_FRONT,  8'd0,  32'd0,         1'b1, '{32'd0, 9'd0, cdq_pkg::ST_EMPTY}},
      '{FUNC_UNUSED_5,            8'hFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 9'd0, cdq_pkg::ST_RANGE}},
      '{FUNC_UNUSED_6,            8'h00, 32'hFFFF_FFFF, 1'b1, '{32'd0, 9'd0, cdq_pkg::ST_RANGE}},
      '{FUNC_UNUSED_7,            8'hFF, 32'd0,         1'b1, '{32'd0, 9'd0, cdq_pkg::ST_RANGE}},
      '{cdq_pkg::FUNC_PUSH_BACK,  8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 9'd1, cdq_pkg::ST_OK}},
      '{cdq_pkg::FUNC_PUSH_FRONT, 8'h00, 32'd0,         1'b1, '{32'd0, 9'd2, cdq_pkg::ST_OK}},
      '{cdq_pkg::FUNC_PUSH_FRONT, 8'h5A, 32'hA5A5_A5A5, 1'b0, UNTYPED},
      '{cdq_pkg::FUNC_PUSH_BACK,  8'hA5, 32'h5A5A_5A5A, 1'b0, UNTYPED},
      '{cdq_pkg::FUNC_READ,       8'd0,  32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{cdq_pkg::FUNC_READ,       8'd3,  32'd0,         1'b0, UNTYPED},
      '{cdq_pkg::FUNC_READ,       8'd4,  32'd0,         1'b1, '{32'd0, 9'd4, cdq_pkg::ST_RANGE}},
      '{cdq_pkg::FUNC_READ,       8'hFF, 32'd0,         1'b1, '{32'd0, 9'd4, cdq_pkg::ST_RANGE}},
      '{cdq_pkg::FUNC_POP_FRONT,  8'd0,  32'd0,         1'b0, UNTYPED},
      '{cdq_pkg::FUNC_POP_BACK,   8'd0,  32'd0,         1'b0, UNTYPED},
      '{cdq_pkg::FUNC_READ,       8'd1,  32'd0,         1'b0, UNTYPED},
      '{FUNC_UNUSED_5,            8'd0,  32'h1234_5678, 1'b1, '{32'd0, 9'd2, cdq_pkg::ST_RANGE}},
      '{cdq_pkg::FUNC_POP_FRONT,  8'd0,  32'd0,         1'b0, UNTYPED},
      '{cdq_pkg::FUNC_POP_FRONT,  8'd0,  32'd0,         1'b0, UNTYPED},
      '{cdq_pkg::FUNC_POP_BACK,   8'd0,  32'd0,         1'b1, '{32'd0, 9'd0, cdq_pkg::ST_EMPTY}},
      '{cdq_pkg::FUNC_PUSH_BACK,  8'd0,  32'h8000_0001, 1'b0, UNTYPED},
      '{cdq_pkg::FUNC_POP_BACK,   8'd0,  32'd0,         1'b0, UNTYPED}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [cdq_pkg::FUNC_W-1:0]   req_func = cdq_pkg::FUNC_READ;
   logic [cdq_pkg::INDEX_W-1:0]  req_index = '0;
   logic [cdq_pkg::VALUE_W-1:0]  req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [cdq_pkg::DATA_W-1:0]   rsp_data;
   logic [cdq_pkg::COUNT_W-1:0]  rsp_count;
   logic [cdq_pkg::STATUS_W-1:0] rsp_status;

   circular_deque_with_indexed_read_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_index  (req_index),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

   // shadow copy of the deque
   logic [cdq_pkg::DATA_W-1:0]  shadow_store [STORE_DEPTH];
   logic [cdq_pkg::INDEX_W-1:0] shadow_head = '0;
   logic [cdq_pkg::COUNT_W-1:0] shadow_fill = '0;

   deque_rsp_type  pending_rsp_q [$];
   int             err_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_phase_left = 0;
   int             stall_period = 2;
   deque_rsp_type  got_rsp;
   deque_rsp_type  want_rsp;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Applies one operation to the shadow deque and returns the word it should produce.
   function automatic deque_rsp_type deque_apply(input logic [cdq_pkg::FUNC_W-1:0] f,
                                                 input logic [cdq_pkg::INDEX_W-1:0] idx,
                                                 input logic [cdq_pkg::VALUE_W-1:0] val);
      deque_rsp_type r;
      logic [cdq_pkg::INDEX_W-1:0] slot;
      r = '0;
      r.status = cdq_pkg::ST_OK;
      case (f)
         cdq_pkg::FUNC_READ: begin
            if (idx < shadow_fill) begin
               slot = shadow_head + idx;
               r.data = shadow_store[slot];
            end else begin
               r.status = cdq_pkg::ST_RANGE;
            end
         end
         cdq_pkg::FUNC_PUSH_BACK: begin
            if (shadow_fill == STORE_DEPTH) begin
               r.status = cdq_pkg::ST_FULL;
            end else begin
               slot = shadow_head + shadow_fill[cdq_pkg::INDEX_W-1:0];
               shadow_store[slot] = val;
               shadow_fill = shadow_fill + 1'b1;
               r.data = val;
            end
         end
         cdq_pkg::FUNC_PUSH_FRONT: begin
            if (shadow_fill == STORE_DEPTH) begin
               r.status = cdq_pkg::ST_FULL;
            end else begin
               shadow_head = shadow_head - 1'b1;
               shadow_store[shadow_head] = val;
               shadow_fill = shadow_fill + 1'b1;
               r.data = val;
            end
         end
         cdq_pkg::FUNC_POP_BACK: begin
            if (shadow_fill == 0) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else begin
               shadow_fill = shadow_fill - 1'b1;
               slot = shadow_head + shadow_fill[cdq_pkg::INDEX_W-1:0];
               r.data = shadow_store[slot];
            end
         end
         cdq_pkg::FUNC_POP_FRONT: begin
            if (shadow_fill == 0) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else begin
               r.data = shadow_store[shadow_head];
               shadow_head = shadow_head + 1'b1;
               shadow_fill = shadow_fill - 1'b1;
            end
         end
         default: begin
            r.status = cdq_pkg::ST_RANGE;
         end
      endcase
      r.count = shadow_fill;
      return r;
   endfunction

   // Drives one request word, waits for it to be taken and queues its expected response.
   task automatic send_word(input logic [cdq_pkg::FUNC_W-1:0] f,
                            input logic [cdq_pkg::INDEX_W-1:0] idx,
                            input logic [cdq_pkg::VALUE_W-1:0] val, input bit typed,
                            input deque_rsp_type typed_rsp);
      deque_rsp_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = deque_apply(f, idx, val);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      burst_left--;
   endtask

   // Random word, biased towards growing or shrinking the deque as the mix asks.
   task automatic random_word(input op_mix_type mix);
      logic [cdq_pkg::FUNC_W-1:0]  f;
      logic [cdq_pkg::INDEX_W-1:0] idx;
      logic [cdq_pkg::VALUE_W-1:0] val;
      int p;
      int push_lim;
      int read_lim;
      p = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin push_lim = 92; read_lim = 97; end
         MIX_DRAIN: begin push_lim = 6;  read_lim = 11; end
         default:   begin push_lim = 38; read_lim = 65; end
      endcase
      idx = cdq_pkg::INDEX_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       val = '0;
         1:       val = '1;
         default: val = $urandom;
      endcase
      if (p < 3) begin
         f = cdq_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_5, FUNC_UNUSED_7));
      end else if (p < push_lim) begin
         f = $urandom_range(0, 1) ? cdq_pkg::FUNC_PUSH_FRONT : cdq_pkg::FUNC_PUSH_BACK;
      end else if (p < read_lim) begin
         f = cdq_pkg::FUNC_READ;
         if (shadow_fill != 0 && $urandom_range(0, 9) < 8)
            idx = cdq_pkg::INDEX_W'($urandom_range(0, shadow_fill - 1));
      end else begin
         f = $urandom_range(0, 1) ? cdq_pkg::FUNC_POP_FRONT : cdq_pkg::FUNC_POP_BACK;
      end
      send_word(f, idx, val, 1'b0, UNTYPED);
   endtask

   // Fill runs until the deque is full, drain until empty; then extra words follow.
   task automatic run_segment(input op_mix_type mix, input int extra);
      if (mix == MIX_FILL) begin
         while (shadow_fill != STORE_DEPTH) random_word(mix);
      end else if (mix == MIX_DRAIN) begin
         while (shadow_fill != 0) random_word(mix);
      end
      repeat (extra) random_word(mix);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_tbl[i])
         send_word(directed_tbl[i].func, directed_tbl[i].index, directed_tbl[i].value,
                   directed_tbl[i].typed, directed_tbl[i].rsp);
      run_segment(MIX_BALANCED, 30);
      run_segment(MIX_FILL, 8);
      run_segment(MIX_BALANCED, 30);
      run_segment(MIX_DRAIN, 8);
      run_segment(MIX_BALANCED, 30);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Response side: stall pattern in phases, and the scoreboard check.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_phase_left = $urandom_range(20, 200);
         stall_period = $urandom_range(2, 7);
      end
      stall_phase_left = stall_phase_left - 1;
      case (stall_mode)
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 40);
         STALL_PERIODIC: rsp_stall <= ((cycle_count % stall_period) == 0);
         default:        rsp_stall <= 1'b0;
      endcase

      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got_rsp = '{rsp_data, rsp_count, rsp_status};
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected response word: data %h count %0d status %0d",
                   rsp_data, rsp_count, rsp_status);
            err_count++;
         end else begin
            want_rsp = pending_rsp_q.pop_front();
            if (got_rsp.data !== want_rsp.data) begin
               $error("rsp_data: expected %h, got %h", want_rsp.data, got_rsp.data);
               err_count++;
            end
            if (got_rsp.count !== want_rsp.count) begin
               $error("rsp_count: expected %0d, got %0d", want_rsp.count, got_rsp.count);
               err_count++;
            end
            if (got_rsp.status !== want_rsp.status) begin
               $error("rsp_status: expected %0d, got %0d", want_rsp.status, got_rsp.status);
               err_count++;
            end
         end
      end
   end

endmodule

`default_nettype wire

[sim.f]
rtl/cdq_pkg.sv
rtl/cdq_store.sv
rtl/circular_deque_with_indexed_read_unit.sv
rtl/cdq_checker.sv
tb/tb_top.sv
